[rtl/spq_pkg.sv]
// shared types, constants and status codes for the stable priority queue
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_BITS  = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 16;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NULL  = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    typedef struct packed {
        logic [ID_BITS-1:0]       id;
        logic signed [TAG_W-1:0]  kind;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic eval;
        logic ins;
        logic rem;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

endpackage

[rtl/stable_priority_queue_core.sv]
// stable priority queue core: sorted chain of cells with request sequencer
// s_axis carries requests: tuser[0] is the operation (0 insert, 1 remove),
// tuser[16:1] the kind tag, tdata[15:0] the item handle and tdata[31:16]
// the priority. remove ignores handle, kind and priority.
// m_axis carries one result per request: tdata holds status, count,
// removed handle and removed priority, tuser the removed kind tag.
// entries leave by ascending priority, first-in first among equals.
// sequence: once a request is accepted, the EVAL state has every cell compare
// itself to the new entry, then the APPLY state resolves status, shifts the
// chain and registers the result.
// one request in flight: the next request is taken once the chain has
// shifted, even while the previous result still waits on m_axis.
// reset: the synchronous active-low reset empties the queue (count 0); the
// cell contents are not cleared and are never read before written.
// stall: while m_axis_tready is low with a result held, a finished request
// waits in its resolve cycle and no further request is accepted.
module stable_priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // item_id[15:0], prio[31:16]
    input  logic [16:0] s_axis_tuser,  // func[0], kind[16:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status[2:0], count[9:3], out_item_id[25:10],
                                       // out_prio[41:26], zero fill[47:42]
    output logic [15:0] m_axis_tuser   // out_kind[15:0]
);

    localparam int N = spq_pkg::CAPACITY;

    spq_pkg::t_state     r_state;
    spq_pkg::t_state     n_state;
    logic                r_func;
    spq_pkg::t_entry     r_new;
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    spq_pkg::t_cell_ctrl w_ctrl;

    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [spq_pkg::CNT_W-1:0] r_out_count;
    spq_pkg::t_entry     r_out_entry;
    logic [2:0]          n_status;
    spq_pkg::t_entry     n_out_entry;
    logic                w_fire;

    spq_pkg::t_entry     w_entry [N];
    logic [N-1:0]        w_le;
    logic [N-1:0]        w_hit;
    logic [N-1:0]        w_valid;

    logic                w_accept;
    logic                w_out_free;
    logic                w_full;
    logic                w_dup;

    assign s_axis_tready = (r_state == spq_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_full        = (r_count == spq_pkg::CNT_W'(N));
    assign w_dup         = |w_hit;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            spq_pkg::t_entry w_prev;
            spq_pkg::t_entry w_next;
            logic            w_prev_le;

            assign w_valid[g] = (r_count > spq_pkg::CNT_W'(g));

            if (g == 0) begin : g_first
                assign w_prev    = r_new;
                assign w_prev_le = 1'b1;
            end else begin : g_mid
                assign w_prev    = w_entry[g-1];
                assign w_prev_le = w_le[g-1];
            end

            if (g == N - 1) begin : g_last
                assign w_next = w_entry[g];
            end else begin : g_body
                assign w_next = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (w_ctrl),
                .i_valid   (w_valid[g]),
                .i_new     (r_new),
                .i_prev    (w_prev),
                .i_prev_le (w_prev_le),
                .i_next    (w_next),
                .o_entry   (w_entry[g]),
                .o_le      (w_le[g]),
                .o_hit     (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = spq_pkg::ST_OK;
        n_out_entry = '0;
        w_fire      = 1'b0;
        w_ctrl      = '0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = spq_pkg::S_EVAL;
                end
            end
            spq_pkg::S_EVAL: begin
                w_ctrl.eval = 1'b1;
                n_state     = spq_pkg::S_APPLY;
            end
            spq_pkg::S_APPLY: begin
                if (r_func == spq_pkg::FN_INSERT) begin
                    if (r_new.id == '0) begin
                        n_status = spq_pkg::ST_NULL;
                    end else if (w_full) begin
                        n_status = spq_pkg::ST_FULL;
                    end else if (w_dup) begin
                        n_status = spq_pkg::ST_DUP;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_status = spq_pkg::ST_EMPTY;
                    end else begin
                        n_out_entry = w_entry[0];
                    end
                end
                if (w_out_free) begin
                    w_fire  = 1'b1;
                    n_state = spq_pkg::S_IDLE;
                    if (n_status == spq_pkg::ST_OK) begin
                        if (r_func == spq_pkg::FN_INSERT) begin
                            w_ctrl.ins = 1'b1;
                            n_count    = r_count + spq_pkg::CNT_W'(1);
                        end else begin
                            w_ctrl.rem = 1'b1;
                            n_count    = r_count - spq_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= s_axis_tuser[0];
            r_new.id   <= s_axis_tdata[spq_pkg::ID_BITS-1:0];
            r_new.kind <= s_axis_tuser[16:1];
            r_new.prio <= s_axis_tdata[31:16];
        end
        if (w_fire) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_entry  <= n_out_entry;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_entry.prio, r_out_entry.id, r_out_count, r_out_status};
    assign m_axis_tuser  = r_out_entry.kind;

endmodule

[rtl/spq_cell.sv]
// one slot of the sorted chain: compare flags, shift in from either neighbor
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_valid,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_prev,
    input  logic               i_prev_le,
    input  spq_pkg::t_entry    i_next,
    output spq_pkg::t_entry    o_entry,
    output logic               o_le,
    output logic               o_hit
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            r_le;
    logic            r_hit;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && !r_le) begin
            // first slot past the equal-or-lower run takes the new entry
            n_entry = i_prev_le ? i_new : i_prev;
        end else if (i_ctrl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctrl.eval) begin
            r_le  <= i_valid && ($signed(r_entry.prio) <= $signed(i_new.prio));
            r_hit <= i_valid && (r_entry.id == i_new.id);
        end
    end

    assign o_entry = r_entry;
    assign o_le    = r_le;
    assign o_hit   = r_hit;

endmodule

[rtl/spq_checker.sv]
// port-level checker for the stable priority queue core, with its bind
module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [15:0] m_axis_tuser
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request in flight: no new request right after one is taken
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // reported count never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:3] <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("count above capacity");

    // an empty remove reports zero count and no item
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == spq_pkg::ST_EMPTY
            |-> m_axis_tdata[9:3] == '0 && m_axis_tdata[25:10] == '0)
        else $error("empty remove with nonzero count or item");

    // a full status only when the queue holds capacity entries
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == spq_pkg::ST_FULL
            |-> m_axis_tdata[9:3] == spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("full status below capacity");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[sim/stable_priority_queue_core_tb.sv]
// testbench for the stable priority queue core: random requests checked against a sorted model
`timescale 1ns / 100ps

module stable_priority_queue_core_tb;

    typedef struct packed {
        logic                              func;
        logic [spq_pkg::ID_BITS-1:0]       id;
        logic signed [spq_pkg::TAG_W-1:0]  kind;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        logic                              hold;
    } t_request;

    typedef struct packed {
        logic [2:0]                        status;
        logic [spq_pkg::CNT_W-1:0]         count;
        logic [spq_pkg::ID_BITS-1:0]       id;
        logic signed [spq_pkg::TAG_W-1:0]  kind;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
    } t_outcome;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // item_id[15:0], prio[31:16]
    logic [16:0] s_axis_tuser = '0;  // func[0], kind[16:1]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // status[2:0], count[9:3], out_item_id[25:10],
                                     // out_prio[41:26], zero fill[47:42]
    logic [15:0] m_axis_tuser;       // out_kind[15:0]

    t_request        pending_requests[$];
    t_outcome        expected_outcomes[$];
    spq_pkg::t_entry sorted_entries[$];
    int              error_count = 0;
    int              idle_cycles = 0;

    stable_priority_queue_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // apply one request to the sorted model and return the outcome it should give
    function automatic t_outcome apply_request(t_request req);
        t_outcome        res;
        spq_pkg::t_entry ent;
        bit              dup;
        int              pos;
        int              i;
        res = '0;
        if (req.func == spq_pkg::FN_INSERT) begin
            dup = 1'b0;
            for (i = 0; i < sorted_entries.size(); i++)
                if (sorted_entries[i].id == req.id) dup = 1'b1;
            if (req.id == '0) begin
                res.status = spq_pkg::ST_NULL;
            end else if (sorted_entries.size() >= spq_pkg::CAPACITY) begin
                res.status = spq_pkg::ST_FULL;
            end else if (dup) begin
                res.status = spq_pkg::ST_DUP;
            end else begin
                // equal priorities go behind the ones already queued
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos].prio <= req.prio)
                    pos++;
                ent.id   = req.id;
                ent.kind = req.kind;
                ent.prio = req.prio;
                sorted_entries.insert(pos, ent);
                res.status = spq_pkg::ST_OK;
            end
        end else begin
            if (sorted_entries.size() == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                ent = sorted_entries.pop_front();
                res.status = spq_pkg::ST_OK;
                res.id     = ent.id;
                res.kind   = ent.kind;
                res.prio   = ent.prio;
            end
        end
        res.count = spq_pkg::CNT_W'(sorted_entries.size());
        return res;
    endfunction

    function automatic void add_request(logic func, logic [spq_pkg::ID_BITS-1:0] id,
                                        logic [15:0] kind, logic [15:0] prio, logic hold);
        t_request req;
        req.func = func;
        req.id   = id;
        req.kind = kind;
        req.prio = prio;
        req.hold = hold;
        pending_requests.push_back(req);
    endfunction

    // half the time a small pool of handles so duplicates show up, sometimes null
    function automatic logic [spq_pkg::ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 55)
            return spq_pkg::ID_BITS'($urandom_range(1, 48));
        else
            return spq_pkg::ID_BITS'($urandom_range(1, 65535));
    endfunction

    // narrow priorities to force ties, wide ones to reach the extremes
    function automatic logic [15:0] pick_prio();
        if ($urandom_range(0, 1) == 0)
            return 16'($signed($urandom_range(0, 6)) - 3);
        else
            return 16'($urandom());
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin : drive_requests
        t_request   cur_req;
        logic       next_valid;
        int         burst_left;
        int         gap_left;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outcomes.push_back(apply_request(cur_req));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].hold && expected_outcomes.size() > 0)) begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tdata <= {cur_req.prio, cur_req.id};
                    s_axis_tuser <= {cur_req.kind, cur_req.func};
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 6);
                        gap_left   = $urandom_range(0, 8);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // receiver: one of four stall patterns, chosen at random and switched periodically
    always @(posedge i_clk) begin : drive_ready
        int cyc;
        int stall_mode;
        logic ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            cyc        = 0;
            stall_mode = 0;
        end else begin
            if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: ready = 1'b1;
                1: ready = ($urandom_range(0, 9) > 2);
                2: ready = (cyc % 5 != 0);
                default: ready = (cyc % 16 < 8);
            endcase
            m_axis_tready <= ready;
            cyc++;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result with no request waiting: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = expected_outcomes.pop_front();
                compare_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
                compare_field("count", 32'(want.count), 32'(m_axis_tdata[9:3]));
                compare_field("out_item_id", 32'(want.id), 32'(m_axis_tdata[25:10]));
                compare_field("out_prio", 32'(want.prio), 32'($signed(m_axis_tdata[41:26])));
                compare_field("out_kind", 32'(want.kind), 32'($signed(m_axis_tuser)));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int          total;
        int          mode;
        int          len;
        int          k;
        logic [15:0] first_id;

        // empty remove, null handle, extremes, duplicate, ties
        add_request(spq_pkg::FN_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0000, 16'h7FFF, 16'h8000, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0001, 16'h7FFF, 16'h8000, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0001, 16'h0005, 16'h0000, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h8000, 16'h0000, 16'h0000, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0002, 16'h000A, 16'h0000, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0003, 16'h000B, 16'h0000, 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0004, 16'hFFFF, 16'h8000, 1'b0);
        for (k = 0; k < 7; k++)
            add_request(spq_pkg::FN_REMOVE, 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'hFFFF, 16'h1234, 16'hFFFF, 1'b0);
        add_request(spq_pkg::FN_REMOVE, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        total = 18;

        // fill to capacity, then try a null and a present handle on the full queue
        first_id = 16'($urandom_range(1, 65535));
        add_request(spq_pkg::FN_INSERT, first_id, 16'($urandom()), pick_prio(), 1'b1);
        for (k = 0; k < 69; k++)
            add_request(spq_pkg::FN_INSERT, 16'($urandom_range(1, 65535)), 16'($urandom()),
                        16'($urandom_range(0, 15) - 8), 1'b0);
        add_request(spq_pkg::FN_INSERT, 16'h0000, 16'($urandom()), pick_prio(), 1'b0);
        add_request(spq_pkg::FN_INSERT, first_id, 16'($urandom()), pick_prio(), 1'b0);
        for (k = 0; k < 66; k++)
            add_request(spq_pkg::FN_REMOVE, 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 1'b0);
        total += 138;

        // random phases: filling, draining and mixed
        while (total < 550) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(15, 60);
            if (len > 550 - total) len = 550 - total;
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < (mode == 0 ? 85 : mode == 1 ? 15 : 50))
                    add_request(spq_pkg::FN_INSERT, pick_id(), 16'($urandom()), pick_prio(),
                                k == 0 && $urandom_range(0, 2) == 0);
                else
                    add_request(spq_pkg::FN_REMOVE, 16'($urandom()), 16'($urandom()),
                                16'($urandom()), k == 0 && $urandom_range(0, 2) == 0);
            end
            total += len;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
